// File: src/spq_pkg.sv
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } cell_ctrl_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_gt,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               gt
);
    import spq_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic        [PRIO_W-1:0] prio_reg;
    logic        [PRIO_W-1:0] prio_next;

    // new entry belongs at or before this cell
    assign gt = !valid_reg || (prio_reg > ctrl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        if (ctrl.ins && gt)
        begin
            if (left_gt)
            begin
                valid_next = left_entry.valid;
                data_next  = left_entry.data;
                prio_next  = left_entry.prio;
            end
            else
            begin
                valid_next = 1'b1;
                data_next  = ctrl.data;
                prio_next  = ctrl.prio;
            end
        end
        else if (ctrl.rem)
        begin
            valid_next = right_entry.valid;
            data_next  = right_entry.data;
            prio_next  = right_entry.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;
    assign entry.prio  = prio_reg;

endmodule

// File: src/stable_priority_queue_unit.sv
// result: done strobes in the cycle after its request is accepted
// throughput: one request per cycle; every cell compares and shifts in the same cycle
// busy stays low, so start may be high in every cycle
// reset: rst_n asynchronous active low empties the queue and clears done
// results cannot be stalled: each appears on done for exactly one cycle
module stable_priority_queue_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic signed [spq_pkg::DATA_W-1:0] in_data,
    input  logic        [spq_pkg::PRIO_W-1:0] in_priority,
    output logic                              done,
    output logic signed [spq_pkg::DATA_W-1:0] out_data,
    output logic        [spq_pkg::PRIO_W-1:0] out_priority,
    output logic      [spq_pkg::STATUS_W-1:0] status,
    output logic        [spq_pkg::FILL_W-1:0] fill_count
);
    import spq_pkg::*;

    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_gt    [QUEUE_DEPTH];
    cell_ctrl_t ctrl;
    entry_t     empty_entry;

    logic                     full;
    logic                     empty;
    logic                     do_ins;
    logic                     do_rem;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    status_t                  status_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic        [PRIO_W-1:0] prio_reg;
    logic        [PRIO_W-1:0] prio_next;
    status_t                  status_reg;

    assign busy        = 1'b0;
    assign full        = cell_entry[QUEUE_DEPTH-1].valid;
    assign empty       = !cell_entry[0].valid;
    assign do_ins      = start && (cmd_t'(cmd) == CMD_INSERT) && !full;
    assign do_rem      = start && (cmd_t'(cmd) == CMD_REMOVE) && !empty;
    assign empty_entry = '0;

    assign ctrl.ins  = do_ins;
    assign ctrl.rem  = do_rem;
    assign ctrl.data = in_data;
    assign ctrl.prio = in_priority;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            logic   left_g;
            entry_t right_e;
            if (i == 0)
            begin : g_first
                assign left_e = empty_entry;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[i-1];
                assign left_g = cell_gt[i-1];
            end
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = empty_entry;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[i+1];
            end
            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .entry       (cell_entry[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        data_next   = '0;
        prio_next   = '0;
        status_next = ST_INSERTED;
        case (cmd_t'(cmd))
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_REMOVED;
                    count_next  = count_reg - CNT_W'(1);
                    data_next   = cell_entry[0].data;
                    prio_next   = cell_entry[0].prio;
                end
            end
            default:
            begin
                status_next = ST_INSERTED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg   <= data_next;
            prio_reg   <= prio_next;
            status_reg <= status_next;
        end
    end

    assign done         = done_reg;
    assign out_data     = data_reg;
    assign out_priority = prio_reg;
    assign status       = status_reg;
    assign fill_count   = FILL_W'(count_reg);

endmodule

// File: bench/queue_order_checker.sv
module queue_order_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                cmd,
    input  logic signed [spq_pkg::DATA_W-1:0]   in_data,
    input  logic        [spq_pkg::PRIO_W-1:0]   in_priority,
    input  logic                                done,
    input  logic signed [spq_pkg::DATA_W-1:0]   out_data,
    input  logic        [spq_pkg::PRIO_W-1:0]   out_priority,
    input  logic        [spq_pkg::STATUS_W-1:0] status,
    input  logic        [spq_pkg::FILL_W-1:0]   fill_count,
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
        status_t                  stat;
        logic        [FILL_W-1:0] fill;
    } queue_reply_t;

    logic signed [DATA_W-1:0] held_data [QUEUE_DEPTH];
    logic        [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
    int                       held_count;
    queue_reply_t             expected_replies [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        held_count  = 0;
    end

    // sorted insert after equal priorities, remove from the head
    function automatic queue_reply_t serve_request(cmd_t op, logic signed [DATA_W-1:0] d,
                                                   logic [PRIO_W-1:0] p);
        queue_reply_t r;
        int           pos;
        r = '0;
        if (op == CMD_INSERT)
        begin
            if (held_count >= QUEUE_DEPTH)
                r.stat = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= p)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[pos] = d;
                held_prio[pos] = p;
                held_count++;
                r.stat = ST_INSERTED;
            end
        end
        else
        begin
            if (held_count == 0)
                r.stat = ST_EMPTY;
            else
            begin
                r.data = held_data[0];
                r.prio = held_prio[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_data[i-1] = held_data[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
                r.stat = ST_REMOVED;
            end
        end
        r.fill = FILL_W'(held_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t want;
        if (!rst_n)
        begin
            held_count = 0;
            expected_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (start && !busy)
                expected_replies.push_back(serve_request(cmd_t'(cmd), in_data, in_priority));
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t unexpected result: data %0d prio %0d status %0d fill %0d",
                                 $realtime, out_data, out_priority, status, fill_count);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (out_data !== want.data || out_priority !== want.prio ||
                        status !== want.stat || fill_count !== want.fill)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%t mismatch: expected data %0d prio %0d status %0d ",
                                      "fill %0d, got data %0d prio %0d status %0d fill %0d"},
                                     $realtime, want.data, want.prio, want.stat, want.fill,
                                     out_data, out_priority, status, fill_count);
                    end
                end
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

// File: bench/tb_stable_priority_queue_unit.sv
module tb_stable_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       cmd;
    logic signed [DATA_W-1:0]   in_data;
    logic        [PRIO_W-1:0]   in_priority;
    logic                       done;
    logic signed [DATA_W-1:0]   out_data;
    logic        [PRIO_W-1:0]   out_priority;
    logic        [STATUS_W-1:0] status;
    logic        [FILL_W-1:0]   fill_count;
    int                         mismatches;
    int                         outstanding;

    stable_priority_queue_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .in_data      (in_data),
        .in_priority  (in_priority),
        .done         (done),
        .out_data     (out_data),
        .out_priority (out_priority),
        .status       (status),
        .fill_count   (fill_count)
    );

    queue_order_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .in_data      (in_data),
        .in_priority  (in_priority),
        .done         (done),
        .out_data     (out_data),
        .out_priority (out_priority),
        .status       (status),
        .fill_count   (fill_count),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // hold one request on the pins until an edge accepts it
    task automatic issue(cmd_t op, logic signed [DATA_W-1:0] d, logic [PRIO_W-1:0] p);
        start       <= 1'b1;
        cmd         <= op;
        in_data     <= d;
        in_priority <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio(int shape);
        case (shape)
            0:       return PRIO_W'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int sent;
        int burst;
        int insert_pct;
        int prio_shape;
        int segment;
        int drain_wait;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= CMD_INSERT;
        in_data     <= '0;
        in_priority <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, field extremes, ties in arrival order
        issue(CMD_REMOVE, 32'sh7fffffff, 8'hff);
        issue(CMD_INSERT, 32'sh7fffffff, 8'hff);
        issue(CMD_INSERT, 32'sh80000000, 8'h00);
        issue(CMD_INSERT, 32'sh00000000, 8'h80);
        issue(CMD_INSERT, -32'sd1, 8'h80);
        issue(CMD_INSERT, 32'sh55555555, 8'h80);
        issue(CMD_INSERT, 32'sh2aaaaaaa, 8'h00);
        issue(CMD_INSERT, 32'sh12345678, 8'hff);
        pause(2);
        for (int i = 0; i < 8; i++)
            issue(CMD_REMOVE, $urandom, PRIO_W'($urandom));
        issue(CMD_REMOVE, '1, 8'hff);
        issue(CMD_INSERT, 32'sh00000001, 8'h01);
        issue(CMD_REMOVE, '0, 8'h00);
        issue(CMD_REMOVE, '0, 8'h00);

        // random: insert-heavy, remove-heavy and balanced stretches
        sent    = 0;
        segment = 0;
        while (sent < 2000)
        begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            prio_shape = $urandom_range(0, 2);
            segment    = $urandom_range(20, 60);
            while (segment > 0 && sent < 2000)
            begin
                burst = $urandom_range(1, 30);
                while (burst > 0 && segment > 0)
                begin
                    issue($urandom_range(0, 99) < insert_pct ? CMD_INSERT : CMD_REMOVE,
                          $urandom, pick_prio(prio_shape));
                    burst--;
                    segment--;
                    sent++;
                end
                pause($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
            end
        end
        start <= 1'b0;

        drain_wait = 0;
        @(negedge clk);
        while (outstanding != 0 && drain_wait < 1000)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
